/* rtl/core/srdd_pkg.sv */
package srdd_pkg;

  localparam int unsigned UNIT_W        = 16;
  localparam int unsigned MASK_W        = 16;
  localparam int unsigned IDX_FIELD_W   = 4;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CNT_FIELD_W   = 5;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned MAX_PROCS_DEF = 16;

  // stream word layout
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DETECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  typedef struct packed {
    logic wr_set;
    logic wr_add;
    logic start;
    logic step;
    logic load_out;
  } srdd_cmd_t;

  typedef struct packed {
    logic none_active;
    logic last;
    logic more;
  } srdd_stat_t;

endpackage

/* rtl/core/srdd_datapath.sv */
module srdd_datapath
  import srdd_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [UNIT_W-1:0]      cfg_data_i,
  input  logic [IDX_FIELD_W-1:0] in_idx_i,
  input  logic [UNIT_W-1:0]      in_held_i,
  input  logic [UNIT_W-1:0]      in_req_i,
  input  srdd_cmd_t              cmd_i,
  output srdd_stat_t             stat_o,
  output logic                   out_found_o,
  output logic [MASK_W-1:0]      out_mask_o
);

  localparam int unsigned DEPTH  = (MAX_PROCS < MASK_W) ? MAX_PROCS : MASK_W;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POOL_W = UNIT_W + $clog2(DEPTH + 1);
  localparam logic [CNT_FIELD_W:0] DEPTH_C = (CNT_FIELD_W + 1)'(DEPTH);

  logic [UNIT_W-1:0]      held_q [DEPTH];
  logic [UNIT_W-1:0]      req_q  [DEPTH];
  logic [UNIT_W-1:0]      avail_q;
  logic [CNT_FIELD_W-1:0] count_q;
  logic [POOL_W-1:0]      pool_q, pool_d;
  logic [DEPTH-1:0]       done_q, done_d;
  logic                   chg_q, chg_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       act_q, act_d;
  logic                   found_q;
  logic [MASK_W-1:0]      mask_q;

  logic [IDX_W-1:0]  rd_addr;
  logic [UNIT_W-1:0] rd_held, rd_req;
  logic [UNIT_W:0]   add_sum;
  logic [UNIT_W-1:0] add_sat;
  logic              idx_ok;
  logic              fits, fire, mark, last;
  logic [DEPTH-1:0]  active;
  logic [DEPTH-1:0]  stuck;

  // single read port shared by the scan and the request add
  assign rd_addr = cmd_i.step ? idx_q : in_idx_i[IDX_W-1:0];
  assign rd_held = held_q[rd_addr];
  assign rd_req  = req_q[rd_addr];

  assign add_sum = {1'b0, rd_req} + {1'b0, in_req_i};
  assign add_sat = add_sum[UNIT_W] ? {UNIT_W{1'b1}} : add_sum[UNIT_W-1:0];
  assign idx_ok  = (32'(in_idx_i) < MAX_PROCS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_set && idx_ok) begin
      held_q[in_idx_i[IDX_W-1:0]] <= in_held_i;
      req_q[in_idx_i[IDX_W-1:0]]  <= in_req_i;
    end else if (cmd_i.wr_add && idx_ok) begin
      req_q[in_idx_i[IDX_W-1:0]] <= add_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AVAIL: avail_q <= cfg_data_i;
        CFG_COUNT: count_q <= cfg_data_i[CNT_FIELD_W-1:0];
        default:   ;
      endcase
    end
  end

  // a process holding nothing finishes without adding to the pool or counting as progress
  assign fits = (POOL_W'(rd_req) <= pool_q);
  assign fire = cmd_i.step && !done_q[idx_q] && (rd_held != '0) && fits;
  assign mark = cmd_i.step && !done_q[idx_q] && ((rd_held == '0) || fits);
  assign last = ((CNT_W'(idx_q) + CNT_W'(1)) == act_q);

  always_comb begin
    pool_d = pool_q;
    done_d = done_q;
    chg_d  = chg_q;
    idx_d  = idx_q;
    act_d  = act_q;
    if (cmd_i.start) begin
      pool_d = POOL_W'(avail_q);
      done_d = '0;
      chg_d  = 1'b0;
      idx_d  = '0;
      act_d  = ({1'b0, count_q} > DEPTH_C) ? CNT_W'(DEPTH) : CNT_W'(count_q);
    end else if (cmd_i.step) begin
      if (fire) begin
        pool_d = pool_q + POOL_W'(rd_held);
      end
      if (mark) begin
        done_d[idx_q] = 1'b1;
      end
      if (last) begin
        idx_d = '0;
        chg_d = 1'b0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
        chg_d = chg_q | fire;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '0;
      done_q <= '0;
      chg_q  <= 1'b0;
      idx_q  <= '0;
      act_q  <= '0;
    end else begin
      pool_q <= pool_d;
      done_q <= done_d;
      chg_q  <= chg_d;
      idx_q  <= idx_d;
      act_q  <= act_d;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      active[i] = (CNT_W'(i) < act_q);
    end
  end

  assign stuck = ~done_q & active;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q <= |stuck;
      mask_q  <= MASK_W'(stuck);
    end
  end

  assign stat_o.none_active = (count_q == '0);
  assign stat_o.last        = last;
  assign stat_o.more        = chg_q | fire;
  assign out_found_o        = found_q;
  assign out_mask_o         = mask_q;

endmodule

/* rtl/core/srdd_ctrl.sv */
module srdd_ctrl
  import srdd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srdd_cmd_t         cmd_o,
  input  srdd_stat_t        stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_SET: cmd_o.wr_set = 1'b1;
            KIND_ADD: cmd_o.wr_add = 1'b1;
            KIND_DETECT: begin
              cmd_o.start = 1'b1;
              state_d     = stat_i.none_active ? S_DONE : S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        // stop after a full pass that returned no units to the pool
        if (stat_i.last && !stat_i.more) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/single_resource_deadlock_detector.sv */
// Deadlock detector for one resource type over a small process table.
// Input stream: each word carries a kind in tuser. A set word loads the held
// and requested units of one entry, an add word raises an entry's request
// (saturating), a detect word runs detection. Set, add and unused kinds give
// no output word.
// Detection walks the table one entry per cycle, repeating passes until a
// pass returns no units to the work pool. Each step is a single
// compare-and-accumulate on the work pool.
// The input is not ready during detection. One output word per detect word:
// deadlock flag and mask of unfinished processes, held in an output register.
// A stalled receiver does not block set or add words; a further detect word
// waits at its end until the previous result has been taken.
// Reset clears the configuration registers and the controller; table entries
// hold nothing defined until they are set.
// Configuration: cfg_we_i with cfg_idx_i 0 writes the available units,
// 1 the process count. Write only while the block is idle.
module single_resource_deadlock_detector
  import srdd_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [UNIT_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // process_index [3:0], held_units [19:4], request_units [35:20], zeros above
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // deadlock_found [0], deadlocked_mask [16:1], zeros above
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  srdd_cmd_t         cmd;
  srdd_stat_t        stat;
  logic              out_found;
  logic [MASK_W-1:0] out_mask;

  srdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  srdd_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_idx_i    (s_axis_tdata[IDX_FIELD_W-1:0]),
    .in_held_i   (s_axis_tdata[IDX_FIELD_W+UNIT_W-1:IDX_FIELD_W]),
    .in_req_i    (s_axis_tdata[IDX_FIELD_W+2*UNIT_W-1:IDX_FIELD_W+UNIT_W]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_found_o (out_found),
    .out_mask_o  (out_mask)
  );

  assign m_axis_tdata = {{(M_TDATA_W-MASK_W-1){1'b0}}, out_mask, out_found};

endmodule

/* rtl/core/srdd_checker.sv */
module srdd_checker
  import srdd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [KIND_W-1:0]    s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // output word held while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // the flag always agrees with the mask
  a_flag_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[MASK_W:1] != '0)))
    else $error("deadlock flag disagrees with mask");

  // a detect word blocks the input while the scan runs
  a_detect_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_DETECT) |=> !s_axis_tready)
    else $error("input ready during detection");

  // table updates never block the input
  a_update_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != KIND_DETECT) |=> s_axis_tready)
    else $error("input stalled after a table update");

endmodule

bind single_resource_deadlock_detector srdd_checker u_srdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
